>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the backoff timer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked on i_clk, idle while i_rst_n is low, with a custom message.
`define CBT_ASSERT_MSG(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Same, with a stock message.
`define CBT_ASSERT(label, prop) \
    `CBT_ASSERT_MSG(label, prop, "cbt assertion failed")

`endif

>>> sv/cbt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbt_pkg
// Shared types, codes and helpers of the CSMA backoff timer.
// ----------------------------------------------------------------------------
package cbt_pkg;

    // cap on the contention window exponent
    localparam int ExpMax  = 16;
    localparam int DvdW    = 32;
    localparam int DivW    = 24;
    localparam int RegIdxW = 3;

    localparam logic [31:0] LfsrTaps = 32'h8020_0003;

    localparam logic [1:0] CmdStart = 2'd0;
    localparam logic [1:0] CmdNav   = 2'd1;
    localparam logic [1:0] CmdRssi  = 2'd2;
    localparam logic [1:0] CmdTick  = 2'd3;

    localparam logic [3:0] FrameAck = 4'd2;
    localparam logic [3:0] FrameRts = 4'd4;
    localparam logic [3:0] FrameCts = 4'd5;

    localparam logic [1:0] EvExpired = 2'd0;
    localparam logic [1:0] EvRefused = 2'd1;
    localparam logic [1:0] EvBusyEnd = 2'd2;

    localparam logic [1:0] ModeExp   = 2'd1;
    localparam logic [1:0] ModeConst = 2'd2;
    localparam logic [1:0] ModeRand  = 2'd3;

    localparam logic [RegIdxW-1:0] RegMode   = 3'd0;
    localparam logic [RegIdxW-1:0] RegSlot   = 3'd1;
    localparam logic [RegIdxW-1:0] RegMin    = 3'd2;
    localparam logic [RegIdxW-1:0] RegMax    = 3'd3;
    localparam logic [RegIdxW-1:0] RegMinExp = 3'd4;
    localparam logic [RegIdxW-1:0] RegCsEn   = 3'd5;
    localparam logic [RegIdxW-1:0] RegThr    = 3'd6;

    typedef struct packed {
        logic [1:0]         backoff_mode;
        logic [15:0]        slot_ticks;
        logic [23:0]        min_backoff_ticks;
        logic [23:0]        max_backoff_ticks;
        logic [4:0]         min_window_exponent;
        logic               carrier_sense_enable;
        logic signed [15:0] busy_threshold;
    } t_cfg;

    // Galois LFSR, one advance per draw
    function automatic logic [31:0] lfsr_next(input logic [31:0] cur);
        logic [31:0] nxt;
        nxt = cur >> 1;
        if (cur[0]) begin
            nxt = nxt ^ LfsrTaps;
        end
        return nxt;
    endfunction

endpackage
`default_nettype wire

>>> sv/cbt_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbt_regs
// APB register file holding the backoff timer configuration.
// ----------------------------------------------------------------------------
module cbt_regs (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [4:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output cbt_pkg::t_cfg      o_cfg
);
    import cbt_pkg::*;

    t_cfg                 r_cfg;
    logic [RegIdxW-1:0]   w_idx;
    logic                 w_wr;

    assign w_idx  = paddr[4:2];
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.backoff_mode         <= ModeExp;
            r_cfg.slot_ticks           <= 16'd1000;
            r_cfg.min_backoff_ticks    <= 24'd0;
            r_cfg.max_backoff_ticks    <= 24'd1000;
            r_cfg.min_window_exponent  <= 5'd0;
            r_cfg.carrier_sense_enable <= 1'b1;
            r_cfg.busy_threshold       <= 16'sd0;
        end else if (w_wr) begin
            unique case (w_idx)
                RegMode:   r_cfg.backoff_mode         <= pwdata[1:0];
                RegSlot:   r_cfg.slot_ticks           <= pwdata[15:0];
                RegMin:    r_cfg.min_backoff_ticks    <= pwdata[23:0];
                RegMax:    r_cfg.max_backoff_ticks    <= pwdata[23:0];
                RegMinExp: r_cfg.min_window_exponent  <= pwdata[4:0];
                RegCsEn:   r_cfg.carrier_sense_enable <= pwdata[0];
                RegThr:    r_cfg.busy_threshold       <= $signed(pwdata[15:0]);
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            RegMode:   prdata = {30'd0, r_cfg.backoff_mode};
            RegSlot:   prdata = {16'd0, r_cfg.slot_ticks};
            RegMin:    prdata = {8'd0, r_cfg.min_backoff_ticks};
            RegMax:    prdata = {8'd0, r_cfg.max_backoff_ticks};
            RegMinExp: prdata = {27'd0, r_cfg.min_window_exponent};
            RegCsEn:   prdata = {31'd0, r_cfg.carrier_sense_enable};
            RegThr:    prdata = {16'd0, r_cfg.busy_threshold};
            default:   prdata = 32'd0;
        endcase
    end

endmodule
`default_nettype wire

>>> sv/cbt_mod_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbt_mod_unit
// Restoring remainder unit: 32-bit dividend mod 24-bit divisor, one bit per
// cycle through a single shared compare/subtract.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module cbt_mod_unit (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [cbt_pkg::DvdW-1:0]  i_dividend,
    input  wire logic [cbt_pkg::DivW-1:0]  i_divisor,
    output logic                           o_done,
    output logic [cbt_pkg::DivW-1:0]       o_rem
);
    import cbt_pkg::*;

    localparam int CntW = $clog2(DvdW);

    logic                r_busy;
    logic                r_done;
    logic [CntW-1:0]     r_cnt;
    logic [DvdW-1:0]     r_dvd;
    logic [DivW-1:0]     r_rem;
    logic [DivW-1:0]     r_div;
    logic [DivW:0]       w_trial;
    logic [DivW:0]       w_diff;
    logic                w_fits;

    // shift in the next dividend bit, subtract when it fits
    assign w_trial = {r_rem, r_dvd[DvdW-1]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_fits  = w_trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CntW'(DvdW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= r_dvd << 1;
            r_rem <= w_fits ? w_diff[DivW-1:0] : w_trial[DivW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

    `CBT_ASSERT(a_done_follows_busy, r_done |-> $past(r_busy))
    `CBT_ASSERT_MSG(a_rem_below_div, r_done |-> (r_rem < r_div), "remainder not reduced")

endmodule
`default_nettype wire

>>> sv/csma_backoff_timer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csma_backoff_timer
// CSMA/CA backoff timer: exponential, constant and uniform random backoff,
// carrier-sense freeze, NAV extension and busy-period reports.
// ----------------------------------------------------------------------------
//  channel   signals                        beat
//  in        i_in_valid / o_in_stall        one command item
//  out       o_out_valid / i_out_stall      one event report
//  cfg       psel penable pwrite paddr ...  one register write or read
//
//  Tick, RSSI and NAV commands, constant-mode and refused starts complete in
//  the accept cycle unless they draw a random number. An exponential start
//  that draws a slot count adds one multiply stage (S_MUL); a random-mode
//  start that draws runs the accept cycle, the u_mod remainder steps, then the load.
//  i_rst_n is synchronous, active low: clears all state, LFSR to 1, config to
//  its defaults. The input stalls while the sequencer works and while a
//  report is held by i_out_stall.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module csma_backoff_timer (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [1:0]         i_command,
    input  wire logic [3:0]         i_frame_type,
    input  wire logic [3:0]         i_num_transmission,
    input  wire logic [15:0]        i_nav_ticks,
    input  wire logic signed [15:0] i_rssi_level,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [1:0]              o_event_kind,
    output logic [3:0]              o_saved_frame_kind,
    output logic [3:0]              o_saved_attempts,
    output logic [31:0]             o_duration_ticks,
    output logic                    o_duration_valid,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    import cbt_pkg::*;

    localparam int RndW = ExpMax;
    localparam int LenW = 41;

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_MOD} t_state;

    t_cfg              w_cfg;
    t_state            r_state, n_state;
    logic              r_in_backoff, n_in_backoff;
    logic [39:0]       r_remaining, n_remaining;
    logic [31:0]       r_elapsed, n_elapsed;
    logic              r_ch_busy, n_ch_busy;
    logic [31:0]       r_busy_len, n_busy_len;
    logic [15:0]       r_pending_nav, n_pending_nav;
    logic [3:0]        r_stored_frame, n_stored_frame;
    logic [3:0]        r_stored_att, n_stored_att;
    logic [31:0]       r_lfsr, n_lfsr;
    logic              r_exp_active, n_exp_active;
    logic [RndW-1:0]   r_rnd, n_rnd;
    logic              r_out_valid, n_out_valid;
    logic [1:0]        r_out_kind, n_out_kind;
    logic [3:0]        r_out_frame, n_out_frame;
    logic [3:0]        r_out_att, n_out_att;
    logic [31:0]       r_out_dur, n_out_dur;
    logic              r_out_dv, n_out_dv;

    logic              w_accept;
    logic [31:0]       w_draw;
    logic [3:0]        w_exp_base;
    logic [5:0]        w_exp_sum;
    logic [5:0]        w_exp_cap;
    logic [32:0]       w_mask;
    logic [RndW+15:0]  w_prod;
    logic [LenW-1:0]   w_mul_len;
    logic [LenW-1:0]   w_nav_sum;
    logic              w_busy_now;
    logic              w_mod_start;
    logic              w_mod_done;
    logic [DivW-1:0]   w_mod_rem;
    logic [DivW-1:0]   w_range;

    logic              begin_req;
    logic              fin_req;
    logic [39:0]       fin_len;
    logic              fin_exp;
    logic              emit_req;
    logic [1:0]        emit_kind;
    logic [31:0]       emit_dur;
    logic              emit_dv;

    cbt_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign w_range = w_cfg.max_backoff_ticks - w_cfg.min_backoff_ticks;

    cbt_mod_unit u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_mod_start),
        .i_dividend (w_draw),
        .i_divisor  (w_range),
        .o_done     (w_mod_done),
        .o_rem      (w_mod_rem)
    );

    assign o_in_stall = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_draw     = lfsr_next(r_lfsr);

    // window exponent: ACK counts as one retry
    assign w_exp_base = (i_frame_type == FrameAck) ? 4'd1 : i_num_transmission;
    assign w_exp_sum  = {2'b00, w_exp_base} + {1'b0, w_cfg.min_window_exponent};
    assign w_exp_cap  = (w_exp_sum > 6'(ExpMax)) ? 6'(ExpMax) : w_exp_sum;
    assign w_mask     = (33'd1 << w_exp_cap) - 33'd1;

    assign w_prod     = r_rnd * w_cfg.slot_ticks;
    assign w_mul_len  = LenW'(w_prod) + LenW'(w_cfg.min_backoff_ticks);
    assign w_nav_sum  = LenW'(r_remaining) + LenW'(i_nav_ticks);
    assign w_busy_now = i_rssi_level > w_cfg.busy_threshold;

    always_comb begin
        n_state        = r_state;
        n_in_backoff   = r_in_backoff;
        n_remaining    = r_remaining;
        n_elapsed      = r_elapsed;
        n_ch_busy      = r_ch_busy;
        n_busy_len     = r_busy_len;
        n_pending_nav  = r_pending_nav;
        n_stored_frame = r_stored_frame;
        n_stored_att   = r_stored_att;
        n_lfsr         = r_lfsr;
        n_exp_active   = r_exp_active;
        n_rnd          = r_rnd;
        n_out_valid    = r_out_valid && i_out_stall;
        n_out_kind     = r_out_kind;
        n_out_frame    = r_out_frame;
        n_out_att      = r_out_att;
        n_out_dur      = r_out_dur;
        n_out_dv       = r_out_dv;
        begin_req      = 1'b0;
        fin_req        = 1'b0;
        fin_len        = '0;
        fin_exp        = 1'b0;
        emit_req       = 1'b0;
        emit_kind      = EvExpired;
        emit_dur       = '0;
        emit_dv        = 1'b0;
        w_mod_start    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (i_command)
                        CmdStart: begin
                            if (r_in_backoff) begin
                                emit_req  = 1'b1;
                                emit_kind = EvRefused;
                                emit_dv   = 1'b1;
                            end else begin
                                begin_req = 1'b1;
                            end
                        end
                        CmdNav: begin
                            if (i_frame_type == FrameRts || i_frame_type == FrameCts) begin
                                if (!r_in_backoff) begin
                                    n_pending_nav = i_nav_ticks;
                                    begin_req     = 1'b1;
                                end else if (r_exp_active) begin
                                    n_remaining = w_nav_sum[40] ? '1 : w_nav_sum[39:0];
                                end else begin
                                    n_pending_nav = i_nav_ticks;
                                end
                            end
                        end
                        CmdRssi: begin
                            if (w_cfg.backoff_mode == ModeExp && w_cfg.carrier_sense_enable) begin
                                if (w_busy_now && !r_ch_busy) begin
                                    n_busy_len = '0;
                                end
                                if (!w_busy_now && r_ch_busy && r_in_backoff) begin
                                    emit_req  = 1'b1;
                                    emit_kind = EvBusyEnd;
                                    emit_dur  = r_busy_len;
                                    emit_dv   = 1'b1;
                                end
                                n_ch_busy = w_busy_now;
                            end else begin
                                n_ch_busy = 1'b0;
                            end
                        end
                        CmdTick: begin
                            if (r_ch_busy && r_busy_len != '1) begin
                                n_busy_len = r_busy_len + 32'd1;
                            end
                            if (r_in_backoff) begin
                                if (r_elapsed != '1) begin
                                    n_elapsed = r_elapsed + 32'd1;
                                end
                                // exponential countdown freezes while busy
                                if (!(r_exp_active && r_ch_busy &&
                                      w_cfg.carrier_sense_enable)) begin
                                    if (r_remaining != '0) begin
                                        n_remaining = r_remaining - 40'd1;
                                    end
                                    if (n_remaining == '0) begin
                                        n_in_backoff = 1'b0;
                                        emit_req     = 1'b1;
                                        emit_kind    = EvExpired;
                                        emit_dur     = r_exp_active ? n_elapsed : 32'd0;
                                        emit_dv      = r_exp_active;
                                    end
                                end
                            end
                        end
                        default: begin
                        end
                    endcase

                    if (begin_req) begin
                        n_stored_frame = i_frame_type;
                        n_stored_att   = i_num_transmission;
                        unique case (w_cfg.backoff_mode)
                            ModeExp: begin
                                if (w_exp_cap == '0) begin
                                    emit_req  = 1'b1;
                                    emit_kind = EvExpired;
                                    emit_dv   = 1'b1;
                                end else if (n_pending_nav == '0) begin
                                    n_lfsr  = w_draw;
                                    n_rnd   = w_draw[RndW-1:0] & w_mask[RndW-1:0];
                                    n_state = S_MUL;
                                end else begin
                                    fin_req       = 1'b1;
                                    fin_len       = 40'(n_pending_nav);
                                    fin_exp       = 1'b1;
                                    n_pending_nav = '0;
                                end
                            end
                            ModeConst: begin
                                fin_req = 1'b1;
                                fin_len = 40'(w_cfg.min_backoff_ticks);
                            end
                            ModeRand: begin
                                if (w_cfg.max_backoff_ticks > w_cfg.min_backoff_ticks) begin
                                    n_lfsr      = w_draw;
                                    w_mod_start = 1'b1;
                                    n_state     = S_MOD;
                                end else begin
                                    fin_req = 1'b1;
                                    fin_len = 40'(w_cfg.min_backoff_ticks);
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
            S_MUL: begin
                fin_req = 1'b1;
                fin_len = w_mul_len[39:0];
                fin_exp = 1'b1;
                n_state = S_IDLE;
            end
            S_MOD: begin
                if (w_mod_done) begin
                    fin_req = 1'b1;
                    fin_len = 40'(w_mod_rem) + 40'(w_cfg.min_backoff_ticks);
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // start a backoff, or report at once when its length is zero
        if (fin_req) begin
            if (fin_len == '0) begin
                emit_req  = 1'b1;
                emit_kind = EvExpired;
                emit_dur  = '0;
                emit_dv   = fin_exp;
            end else begin
                n_in_backoff = 1'b1;
                n_remaining  = fin_len;
                n_elapsed    = '0;
                n_exp_active = fin_exp;
            end
        end

        if (emit_req) begin
            n_out_valid = 1'b1;
            n_out_kind  = emit_kind;
            n_out_frame = n_stored_frame;
            n_out_att   = n_stored_att;
            n_out_dur   = emit_dur;
            n_out_dv    = emit_dv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_in_backoff   <= 1'b0;
            r_remaining    <= '0;
            r_elapsed      <= '0;
            r_ch_busy      <= 1'b0;
            r_busy_len     <= '0;
            r_pending_nav  <= '0;
            r_stored_frame <= '0;
            r_stored_att   <= '0;
            r_lfsr         <= 32'd1;
            r_exp_active   <= 1'b0;
            r_rnd          <= '0;
            r_out_valid    <= 1'b0;
            r_out_kind     <= EvExpired;
            r_out_frame    <= '0;
            r_out_att      <= '0;
            r_out_dur      <= '0;
            r_out_dv       <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_in_backoff   <= n_in_backoff;
            r_remaining    <= n_remaining;
            r_elapsed      <= n_elapsed;
            r_ch_busy      <= n_ch_busy;
            r_busy_len     <= n_busy_len;
            r_pending_nav  <= n_pending_nav;
            r_stored_frame <= n_stored_frame;
            r_stored_att   <= n_stored_att;
            r_lfsr         <= n_lfsr;
            r_exp_active   <= n_exp_active;
            r_rnd          <= n_rnd;
            r_out_valid    <= n_out_valid;
            r_out_kind     <= n_out_kind;
            r_out_frame    <= n_out_frame;
            r_out_att      <= n_out_att;
            r_out_dur      <= n_out_dur;
            r_out_dv       <= n_out_dv;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_event_kind       = r_out_kind;
    assign o_saved_frame_kind = r_out_frame;
    assign o_saved_attempts   = r_out_att;
    assign o_duration_ticks   = r_out_dur;
    assign o_duration_valid   = r_out_dv;

    `CBT_ASSERT_MSG(a_backoff_nonzero, r_in_backoff |-> (r_remaining != '0), "empty backoff")
    `CBT_ASSERT(a_seq_out_free, (r_state != S_IDLE) |-> !r_out_valid)
    `CBT_ASSERT(a_out_hold, (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_out_dur)))

endmodule
`default_nettype wire
